@@ design/voice_admission_with_preemption_core_assert.svh @@
// assertion macros for the voice admission core
`ifndef VOICE_ADMISSION_WITH_PREEMPTION_CORE_ASSERT_SVH
`define VOICE_ADMISSION_WITH_PREEMPTION_CORE_ASSERT_SVH

// property must hold on every rising clock edge out of reset
`define VAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

@@ design/vap_pkg.sv @@
// ----------------------------------------------------------------------------
// vap_pkg
// shared constants and types for the voice admission core
// ----------------------------------------------------------------------------
package vap_pkg;
  localparam int unsigned MaxVoices = 16;
  localparam int unsigned SlotBits  = 4;
  localparam int unsigned EventIds  = 256;
  localparam int unsigned IdBits    = 8;
  localparam int unsigned TimeBits  = 32;

  localparam logic [2:0] StTick     = 3'd0;
  localparam logic [2:0] StUnknown  = 3'd1;
  localparam logic [2:0] StCooldown = 3'd2;
  localparam logic [2:0] StNoPre    = 3'd3;
  localparam logic [2:0] StPlayed   = 3'd4;
  localparam logic [2:0] StEvict    = 3'd5;
  localparam logic [2:0] StUntrack  = 3'd6;

  typedef struct packed {
    logic [IdBits-1:0]   event_id;
    logic [2:0]          bus;
    logic [7:0]          prio;
    logic [TimeBits-1:0] end_time;
    logic [15:0]         handle;
  } slot_t;
endpackage

@@ design/vap_slot_mem.sv @@
// ----------------------------------------------------------------------------
// vap_slot_mem
// voice slot table, one synchronous read port and one write port
// ----------------------------------------------------------------------------
module vap_slot_mem
  import vap_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [SlotBits-1:0] waddr_i,
  input  slot_t               wdata_i,
  input  logic [SlotBits-1:0] raddr_i,
  output slot_t               rdata_o
);
  slot_t mem_q [MaxVoices];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/vap_time_mem.sv @@
// ----------------------------------------------------------------------------
// vap_time_mem
// last play time per event id, one synchronous read port and one write port
// ----------------------------------------------------------------------------
module vap_time_mem
  import vap_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdBits-1:0]   waddr_i,
  input  logic [TimeBits-1:0] wdata_i,
  input  logic [IdBits-1:0]   raddr_i,
  output logic [TimeBits-1:0] rdata_o
);
  logic [TimeBits-1:0] mem_q [EventIds];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/voice_admission_with_preemption_core.sv @@
// ----------------------------------------------------------------------------
// voice_admission_with_preemption_core
// admits sound events into a sixteen-slot voice table with preemption
//
// channel  direction  signals
// in       input      in_valid_i / in_ready_o, one port per field
// out      output     out_valid_o / out_ready_i, one port per field
//
// one item at a time: a tick runs the expiry scan only; a post scans, then
// decides, and may run a victim search before it stores the new voice.
// the slot memory read port is walked one slot a cycle:
// one pass for expiry and event count, one pass for the victim search.
// reset clears valid bits and counters at once; no clearing pass.
// a new item is taken while the previous result waits in the output register;
// a second result waits in the done state until the output register drains.
// ----------------------------------------------------------------------------
module voice_admission_with_preemption_core
  import vap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [15:0] delta_ticks_i,
  input  logic [7:0]  event_id_i,
  input  logic        event_known_i,
  input  logic [2:0]  bus_index_i,
  input  logic [7:0]  priority_req_i,
  input  logic [4:0]  max_concurrency_i,
  input  logic [15:0] cooldown_ticks_i,
  input  logic [15:0] voice_handle_i,
  input  logic [23:0] duration_ticks_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] evicted_handle_o,
  output logic        new_warning_o,
  output logic [15:0] warning_count_o,
  output logic [4:0]  same_event_count_o,
  output logic [4:0]  total_voices_o,
  output logic [31:0] current_time_o
);
`include "voice_admission_with_preemption_core_assert.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_VICT   = 3'd3;
  localparam logic [2:0] S_STORE  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [SlotBits:0] idx_q, idx_d;

  logic        req_type_q;
  logic [7:0]  id_q;
  logic        known_q;
  logic [2:0]  bus_q;
  logic [7:0]  prio_q;
  logic [4:0]  maxc_q;
  logic [15:0] cool_q;
  logic [15:0] handle_q;
  logic [23:0] dur_q;

  logic [TimeBits-1:0] clock_q, clock_d;
  logic [MaxVoices-1:0] valid_q, valid_d;
  logic [EventIds-1:0] lp_valid_q, lp_valid_d;
  logic [EventIds-1:0] warned_q, warned_d;
  logic [15:0] warn_cnt_q, warn_cnt_d;
  logic [4:0]  same_q, same_d;
  logic [2:0]  status_q, status_d;
  logic [15:0] evict_q, evict_d;
  logic        new_warn_q, new_warn_d;
  logic        low_found_q, low_found_d;
  logic [SlotBits-1:0] low_q, low_d;
  logic [7:0]  low_prio_q, low_prio_d;
  logic [TimeBits-1:0] low_end_q, low_end_d;
  logic [15:0] low_handle_q, low_handle_d;

  logic        ov_q, ov_d;
  logic [2:0]  o_status_q, o_status_d;
  logic [15:0] o_evict_q, o_evict_d;
  logic        o_warn_q, o_warn_d;
  logic [15:0] o_wcnt_q, o_wcnt_d;
  logic [4:0]  o_same_q, o_same_d;
  logic [4:0]  o_total_q, o_total_d;
  logic [31:0] o_time_q, o_time_d;

  logic [SlotBits-1:0] raddr;
  slot_t               rd;
  logic                s_we;
  logic [SlotBits-1:0] s_waddr;
  slot_t               s_wdata;
  logic [TimeBits-1:0] lp_time;
  logic                t_we;

  logic                in_fire;
  logic [SlotBits-1:0] rslot;
  logic [TimeBits:0]   end_sum;
  logic [TimeBits-1:0] end_sat;
  logic                free_found;
  logic [SlotBits-1:0] free_idx;
  logic [4:0]          vcount;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign raddr      = idx_q[SlotBits-1:0];
  assign rslot      = idx_q[SlotBits-1:0] - SlotBits'(1);

  vap_slot_mem u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  vap_time_mem u_time_mem (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (id_q),
    .wdata_i (clock_q),
    .raddr_i (id_q),
    .rdata_o (lp_time)
  );

  always_comb begin
    end_sum = {1'b0, clock_q} + {{(TimeBits + 1 - 24){1'b0}}, dur_q};
    end_sat = end_sum[TimeBits] ? '1 : end_sum[TimeBits-1:0];
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MaxVoices - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotBits'(i);
      end
    end
    vcount = '0;
    for (int i = 0; i < MaxVoices; i++) begin
      vcount = vcount + 5'(valid_q[i]);
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    clock_d      = clock_q;
    valid_d      = valid_q;
    lp_valid_d   = lp_valid_q;
    warned_d     = warned_q;
    warn_cnt_d   = warn_cnt_q;
    same_d       = same_q;
    status_d     = status_q;
    evict_d      = evict_q;
    new_warn_d   = new_warn_q;
    low_found_d  = low_found_q;
    low_d        = low_q;
    low_prio_d   = low_prio_q;
    low_end_d    = low_end_q;
    low_handle_d = low_handle_q;
    ov_d         = ov_q;
    o_status_d   = o_status_q;
    o_evict_d    = o_evict_q;
    o_warn_d     = o_warn_q;
    o_wcnt_d     = o_wcnt_q;
    o_same_d     = o_same_q;
    o_total_d    = o_total_q;
    o_time_d     = o_time_q;
    s_we         = 1'b0;
    s_waddr      = free_idx;
    s_wdata      = '{event_id: id_q, bus: bus_q, prio: prio_q,
                     end_time: end_sat, handle: handle_q};
    t_we         = 1'b0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (in_fire) begin
          if (!req_type_i) begin
            clock_d = clock_q + TimeBits'(delta_ticks_i);
          end
          same_d      = '0;
          evict_d     = '0;
          new_warn_d  = 1'b0;
          low_found_d = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        // slot idx-1 data on rd
        if (idx_q != '0) begin
          if (valid_q[rslot] && rd.end_time <= clock_q) begin
            valid_d[rslot] = 1'b0;
          end else if (valid_q[rslot] && rd.event_id == id_q) begin
            same_d = same_q + 5'd1;
          end
        end
        if (idx_q == (SlotBits + 1)'(MaxVoices)) begin
          state_d = req_type_q ? S_DECIDE : S_DONE;
          status_d = StTick;
          if (!req_type_q) begin
            same_d = '0;
          end
        end else begin
          idx_d = idx_q + (SlotBits + 1)'(1);
        end
      end
      S_DECIDE: begin
        idx_d = '0;
        if (!known_q) begin
          status_d = StUnknown;
          if (!warned_q[id_q]) begin
            warned_d[id_q] = 1'b1;
            new_warn_d = 1'b1;
            if (warn_cnt_q != 16'hffff) begin
              warn_cnt_d = warn_cnt_q + 16'd1;
            end
          end
          state_d = S_DONE;
        end else if (cool_q != '0 && lp_valid_q[id_q] &&
                     (clock_q - lp_time) < TimeBits'(cool_q)) begin
          status_d = StCooldown;
          state_d  = S_DONE;
        end else if (maxc_q != '0 && same_q >= maxc_q) begin
          state_d = S_VICT;
        end else begin
          status_d = StPlayed;
          state_d  = S_STORE;
        end
      end
      S_VICT: begin
        if (idx_q != '0) begin
          if (valid_q[rslot] && rd.bus == bus_q &&
              (!low_found_q || rd.prio < low_prio_q ||
               (rd.prio == low_prio_q && rd.end_time < low_end_q))) begin
            low_found_d  = 1'b1;
            low_d        = rslot;
            low_prio_d   = rd.prio;
            low_end_d    = rd.end_time;
            low_handle_d = rd.handle;
          end
        end
        if (idx_q == (SlotBits + 1)'(MaxVoices)) begin
          if (!low_found_d || prio_q <= low_prio_d) begin
            status_d = StNoPre;
            state_d  = S_DONE;
          end else begin
            evict_d         = low_handle_d;
            valid_d[low_d]  = 1'b0;
            status_d        = StEvict;
            state_d         = S_STORE;
          end
        end else begin
          idx_d = idx_q + (SlotBits + 1)'(1);
        end
      end
      S_STORE: begin
        lp_valid_d[id_q] = 1'b1;
        t_we = 1'b1;
        if (handle_q != '0 && maxc_q != '0 && free_found) begin
          s_we = 1'b1;
          valid_d[free_idx] = 1'b1;
        end else begin
          status_d = StUntrack;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_d) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_evict_d  = evict_q;
          o_warn_d   = new_warn_q;
          o_wcnt_d   = warn_cnt_q;
          o_same_d   = same_q;
          o_total_d  = vcount;
          o_time_d   = clock_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      clock_q    <= '0;
      valid_q    <= '0;
      lp_valid_q <= '0;
      warned_q   <= '0;
      warn_cnt_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      clock_q    <= clock_d;
      valid_q    <= valid_d;
      lp_valid_q <= lp_valid_d;
      warned_q   <= warned_d;
      warn_cnt_q <= warn_cnt_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q <= req_type_i;
      id_q       <= event_id_i;
      known_q    <= event_known_i;
      bus_q      <= bus_index_i;
      prio_q     <= priority_req_i;
      maxc_q     <= max_concurrency_i;
      cool_q     <= cooldown_ticks_i;
      handle_q   <= voice_handle_i;
      dur_q      <= duration_ticks_i;
    end
    same_q       <= same_d;
    status_q     <= status_d;
    evict_q      <= evict_d;
    new_warn_q   <= new_warn_d;
    low_found_q  <= low_found_d;
    low_q        <= low_d;
    low_prio_q   <= low_prio_d;
    low_end_q    <= low_end_d;
    low_handle_q <= low_handle_d;
    o_status_q   <= o_status_d;
    o_evict_q    <= o_evict_d;
    o_warn_q     <= o_warn_d;
    o_wcnt_q     <= o_wcnt_d;
    o_same_q     <= o_same_d;
    o_total_q    <= o_total_d;
    o_time_q     <= o_time_d;
  end

  assign out_valid_o        = ov_q;
  assign status_o           = o_status_q;
  assign evicted_handle_o   = o_evict_q;
  assign new_warning_o      = o_warn_q;
  assign warning_count_o    = o_wcnt_q;
  assign same_event_count_o = o_same_q;
  assign total_voices_o     = o_total_q;
  assign current_time_o     = o_time_q;

  `VAP_ASSERT(a_ready_idle, in_ready_o == (state_q == S_IDLE), "ready outside idle")
  `VAP_ASSERT(a_scan_span, (state_q == S_SCAN) |-> (idx_q <= 5'd16), "scan index out of range")
  `VAP_ASSERT(a_warn_mono, (state_q != S_IDLE) |=> (warn_cnt_q >= $past(warn_cnt_q)), "warning count fell")
  `VAP_ASSERT(a_evict_status, (ov_q && o_status_q == StEvict) |-> (o_evict_q != '0), "evict status")
endmodule
